// File: design/differential_drive_heading_steer_core_defines.svh
// assertion macros for the heading steer core
`ifndef DIFFERENTIAL_DRIVE_HEADING_STEER_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_HEADING_STEER_CORE_DEFINES_SVH

// same-cycle implication on clk with asynchronous reset
`define DHS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk with asynchronous reset
`define DHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/dhs_pkg.sv
// types, constants and tables shared by the heading steer core
package dhs_pkg;

	localparam int CORDIC_STEPS_DEF = 14;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int CW               = 32;
	localparam int ANG_W            = 16;
	localparam int MAG_W            = 14;
	localparam int PROD_W           = 22;

	localparam logic [1:0] REG_TARGET_X   = 2'd0;
	localparam logic [1:0] REG_TARGET_Y   = 2'd1;
	localparam logic [1:0] REG_STEER_GAIN = 2'd2;
	localparam logic [1:0] REG_ARRIVAL    = 2'd3;

	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_BRAKE = 2'd2;

	localparam logic [9:0] DUTY_FULL = 10'd1023;

	localparam logic signed [ANG_W-1:0] QUARTER_POS = 16'sh4000;
	localparam logic signed [ANG_W-1:0] QUARTER_NEG = -16'sh4000;
	localparam logic signed [ANG_W-1:0] EIGHTH_POS  = 16'sh2000;
	localparam logic signed [ANG_W-1:0] EIGHTH_NEG  = -16'sh2000;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_GO   = 2'd1,
		MODE_HOLD = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		SC_ZERO,
		SC_SPIN_NEG,
		SC_SPIN_POS,
		SC_PROP_NEG,
		SC_PROP_POS
	} steer_cls_t;

	typedef struct packed {
		logic       kind;
		logic       near;
		steer_cls_t go_cls;
		logic [9:0] go_duty;
		steer_cls_t hold_cls;
		logic [9:0] hold_duty;
	} cls_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// atan(2^-i) in binary angle units
	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [ANG_W-1:0] v;
		unique case (i)
			4'd0:    v = 16'sd8192;
			4'd1:    v = 16'sd4836;
			4'd2:    v = 16'sd2555;
			4'd3:    v = 16'sd1297;
			4'd4:    v = 16'sd651;
			4'd5:    v = 16'sd326;
			4'd6:    v = 16'sd163;
			4'd7:    v = 16'sd81;
			4'd8:    v = 16'sd41;
			4'd9:    v = 16'sd20;
			4'd10:   v = 16'sd10;
			4'd11:   v = 16'sd5;
			4'd12:   v = 16'sd3;
			4'd13:   v = 16'sd1;
			4'd14:   v = 16'sd1;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: design/dhs_ifs.sv
// valid/ready channel interfaces for pose items and motor results
interface dhs_item_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [11:0] pos_x;
	logic signed [11:0] pos_y;
	logic signed [15:0] heading;

	modport source(output valid, kind, pos_x, pos_y, heading, input ready);
	modport sink(input valid, kind, pos_x, pos_y, heading, output ready);
endinterface

interface dhs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] front_dir;
	logic [1:0] back_dir;
	logic [9:0] front_duty;
	logic [9:0] back_duty;
	logic [1:0] mode_now;
	logic       arrived;

	modport source(output valid, front_dir, back_dir, front_duty, back_duty, mode_now,
		arrived, input ready);
	modport sink(input valid, front_dir, back_dir, front_duty, back_duty, mode_now,
		arrived, output ready);
endinterface

// File: design/differential_drive_heading_steer_core.sv
// top level of the differential drive heading steer core
//
//   channel   dir   word
//   item      in    kind, pos_x, pos_y, heading
//   result    out   front_dir, back_dir, front_duty, back_duty, mode_now, arrived
//   cfg_*     in    register index, data (no handshake)
//
// one word per cycle while results are taken; an item passes the input register, the unrolled
// cordic stages, the error, multiply and scale stages, the queue and the output register
// asynchronous reset clears control state and loads register defaults, no clearing pass
// a stalled result fills the QUEUE_DEPTH-word queue, then the front end halts and item.ready drops
module differential_drive_heading_steer_core #(
	parameter int CORDIC_STEPS = dhs_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = dhs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dhs_item_if.sink     item,
	dhs_result_if.source result,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [11:0]  cfg_data
);
	import dhs_pkg::*;

	`include "differential_drive_heading_steer_core_defines.svh"

	logic signed [11:0] target_x_q, target_y_q;
	logic [7:0]         steer_gain_q;
	logic [9:0]         arrival_radius_q;

	logic               q_push, q_pop;
	cls_word_t          q_in, q_out;
	q_stat_t            q_stat;

	logic               brake_shown;

	assign brake_shown = (result.front_dir == DIR_BRAKE) && (result.back_dir == DIR_BRAKE)
		&& (result.front_duty == '0) && (result.back_duty == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q       <= '0;
			target_y_q       <= '0;
			steer_gain_q     <= 8'd20;
			arrival_radius_q <= 10'd50;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TARGET_X:   target_x_q       <= cfg_data;
				REG_TARGET_Y:   target_y_q       <= cfg_data;
				REG_STEER_GAIN: steer_gain_q     <= cfg_data[7:0];
				REG_ARRIVAL:    arrival_radius_q <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	dhs_front #(
		.STEPS(CORDIC_STEPS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.target_x       (target_x_q),
		.target_y       (target_y_q),
		.steer_gain     (steer_gain_q),
		.arrival_radius (arrival_radius_q),
		.q_stat         (q_stat),
		.push           (q_push),
		.push_word      (q_in)
	);

	dhs_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.pop       (q_pop),
		.pop_word  (q_out),
		.stat      (q_stat)
	);

	dhs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_word (q_out),
		.q_stat (q_stat),
		.pop    (q_pop),
		.result (result)
	);

	`DHS_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "queue written while full")
	`DHS_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty, "queue read while empty")
	`DHS_ASSERT_NOW(a_brake_cmds, result.arrived, brake_shown, "latched brake without brake commands")
	`DHS_ASSERT_NEXT(a_latch_sticks, result.arrived, result.arrived, "brake latch released")

endmodule

// File: design/dhs_front.sv
// front end: bearing cordic pipeline, heading error classification and duty scaling
module dhs_front #(
	parameter int STEPS = dhs_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	dhs_item_if.sink            item,
	input  logic signed [11:0]  target_x,
	input  logic signed [11:0]  target_y,
	input  logic [7:0]          steer_gain,
	input  logic [9:0]          arrival_radius,
	input  dhs_pkg::q_stat_t    q_stat,
	output logic                push,
	output dhs_pkg::cls_word_t  push_word
);
	import dhs_pkg::*;

	typedef struct packed {
		logic                    kind;
		logic                    near;
		logic                    zero;
		logic                    hpos;
		logic signed [ANG_W-1:0] heading;
	} side_t;

	function automatic steer_cls_t classify(input logic signed [ANG_W-1:0] e);
		steer_cls_t c;
		priority if (e == '0)        c = SC_ZERO;
		else if (e < EIGHTH_NEG)     c = SC_SPIN_NEG;
		else if (e > EIGHTH_POS)     c = SC_SPIN_POS;
		else if (e < 0)              c = SC_PROP_NEG;
		else                         c = SC_PROP_POS;
		return c;
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [ANG_W-1:0] e);
		logic [ANG_W-1:0] a;
		a = e[ANG_W-1] ? ANG_W'(-e) : ANG_W'(e);
		return a[MAG_W-1:0];
	endfunction

	function automatic logic [9:0] duty_of(input logic [PROD_W-1:0] p);
		logic [CW-1:0] t;
		logic [15:0]   hi;
		logic [9:0]    s;
		t  = {p, 10'b0} - {10'b0, p};
		hi = t[CW-1:16];
		s  = (hi > 16'(DUTY_FULL)) ? DUTY_FULL : hi[9:0];
		return DUTY_FULL - s;
	endfunction

	logic                    adv;
	logic                    v_s  [STEPS+1];
	side_t                   sd_s [STEPS+1];
	logic signed [CW-1:0]    x_s  [STEPS+1];
	logic signed [CW-1:0]    y_s  [STEPS+1];
	logic signed [ANG_W-1:0] z_s  [STEPS+1];

	logic signed [12:0]      dyc, dxc, ex_abs, ey_abs;
	logic signed [CW-1:0]    xsc, ysc;
	logic signed [CW-1:0]    x0, y0;
	logic signed [ANG_W-1:0] z0;
	side_t                   sd0;

	logic signed [ANG_W-1:0] brg, err_go, err_hold;

	logic                    v_s1, v_s2, v_s3;
	logic                    kind_s1, near_s1, kind_s2, near_s2;
	steer_cls_t              gcls_s1, hcls_s1, gcls_s2, hcls_s2;
	logic [MAG_W-1:0]        gmag_s1, hmag_s1;
	logic [PROD_W-1:0]       gprod_s2, hprod_s2;
	cls_word_t               word_s3;

	assign adv        = !(v_s3 && q_stat.full);
	assign item.ready = adv;
	assign push       = v_s3 && !q_stat.full;
	assign push_word  = word_s3;

	always_comb begin
		dyc    = {item.pos_x[11], item.pos_x} - {target_x[11], target_x};
		dxc    = {target_y[11], target_y} - {item.pos_y[11], item.pos_y};
		ex_abs = dyc[12] ? -dyc : dyc;
		ey_abs = dxc[12] ? -dxc : dxc;
		xsc    = {{3{dxc[12]}}, dxc, 16'b0};
		ysc    = {{3{dyc[12]}}, dyc, 16'b0};
		if (dxc[12]) begin
			if (!dyc[12]) begin
				x0 = ysc;
				y0 = -xsc;
				z0 = QUARTER_POS;
			end else begin
				x0 = -ysc;
				y0 = xsc;
				z0 = QUARTER_NEG;
			end
		end else begin
			x0 = xsc;
			y0 = ysc;
			z0 = '0;
		end
		sd0.kind    = item.kind;
		sd0.near    = (ex_abs < {3'b0, arrival_radius}) && (ey_abs < {3'b0, arrival_radius});
		sd0.zero    = (dxc == '0) && (dyc == '0);
		sd0.hpos    = !target_x[11] && (target_x != '0);
		sd0.heading = item.heading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s[0] <= sd0;
			x_s[0]  <= x0;
			y_s[0]  <= y0;
			z_s[0]  <= z0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sd_s[k+1] <= sd_s[k];
				if (!y_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + atan_lut(4'(k));
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - atan_lut(4'(k));
				end
			end
		end
	end

	always_comb begin
		brg      = sd_s[STEPS].zero ? '0 : z_s[STEPS];
		err_go   = brg - sd_s[STEPS].heading;
		err_hold = (sd_s[STEPS].hpos ? QUARTER_POS : QUARTER_NEG) - sd_s[STEPS].heading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_s[STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= sd_s[STEPS].kind;
			near_s1  <= sd_s[STEPS].near;
			gcls_s1  <= classify(err_go);
			hcls_s1  <= classify(err_hold);
			gmag_s1  <= magnitude(err_go);
			hmag_s1  <= magnitude(err_hold);

			kind_s2  <= kind_s1;
			near_s2  <= near_s1;
			gcls_s2  <= gcls_s1;
			hcls_s2  <= hcls_s1;
			gprod_s2 <= PROD_W'(gmag_s1) * PROD_W'(steer_gain);
			hprod_s2 <= PROD_W'(hmag_s1) * PROD_W'(steer_gain);

			word_s3.kind      <= kind_s2;
			word_s3.near      <= near_s2;
			word_s3.go_cls    <= gcls_s2;
			word_s3.go_duty   <= duty_of(gprod_s2);
			word_s3.hold_cls  <= hcls_s2;
			word_s3.hold_duty <= duty_of(hprod_s2);
		end
	end

endmodule

// File: design/dhs_fifo.sv
// short word queue between the front end and the motor command back end
module dhs_fifo #(
	parameter int DEPTH = dhs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dhs_pkg::cls_word_t push_word,
	input  logic               pop,
	output dhs_pkg::cls_word_t pop_word,
	output dhs_pkg::q_stat_t   stat
);
	import dhs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	cls_word_t       mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [NW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == NW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_word   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/dhs_back.sv
// back end: mode, brake latch and held motor commands, output register
module dhs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dhs_pkg::cls_word_t q_word,
	input  dhs_pkg::q_stat_t   q_stat,
	output logic               pop,
	dhs_result_if.source       result
);
	import dhs_pkg::*;

	mode_t      mode_q, mode_d;
	logic       brake_q, brake_d;
	logic       out_v_q;
	logic [1:0] fdir_q, bdir_q, fdir_d, bdir_d;
	logic [9:0] fduty_q, bduty_q, fduty_d, bduty_d;
	steer_cls_t cls;
	logic [9:0] duty;

	assign pop = !q_stat.empty && (!out_v_q || result.ready);

	assign result.valid      = out_v_q;
	assign result.front_dir  = fdir_q;
	assign result.back_dir   = bdir_q;
	assign result.front_duty = fduty_q;
	assign result.back_duty  = bduty_q;
	assign result.mode_now   = mode_q;
	assign result.arrived    = brake_q;

	always_comb begin
		mode_d  = mode_q;
		brake_d = brake_q;
		fdir_d  = fdir_q;
		bdir_d  = bdir_q;
		fduty_d = fduty_q;
		bduty_d = bduty_q;
		cls     = (mode_q == MODE_GO) ? q_word.go_cls : q_word.hold_cls;
		duty    = (mode_q == MODE_GO) ? q_word.go_duty : q_word.hold_duty;
		if (q_word.kind) begin
			mode_d = MODE_GO;
		end else if (mode_q == MODE_GO || mode_q == MODE_HOLD) begin
			if (!brake_q) begin
				unique case (cls)
					SC_SPIN_NEG: begin
						fdir_d  = DIR_RIGHT;
						bdir_d  = DIR_LEFT;
						fduty_d = DUTY_FULL;
						bduty_d = DUTY_FULL;
					end
					SC_SPIN_POS: begin
						fdir_d  = DIR_LEFT;
						bdir_d  = DIR_RIGHT;
						fduty_d = DUTY_FULL;
						bduty_d = DUTY_FULL;
					end
					SC_PROP_NEG: begin
						fdir_d  = DIR_RIGHT;
						bdir_d  = DIR_RIGHT;
						fduty_d = DUTY_FULL;
						bduty_d = duty;
					end
					SC_PROP_POS: begin
						fdir_d  = DIR_RIGHT;
						bdir_d  = DIR_RIGHT;
						fduty_d = duty;
						bduty_d = DUTY_FULL;
					end
					default: begin
					end
				endcase
			end
			if (q_word.near) begin
				if (mode_q == MODE_GO) begin
					mode_d = MODE_HOLD;
				end
				brake_d = 1'b1;
				fdir_d  = DIR_BRAKE;
				bdir_d  = DIR_BRAKE;
				fduty_d = '0;
				bduty_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			brake_q <= 1'b0;
			out_v_q <= 1'b0;
			fdir_q  <= DIR_RIGHT;
			bdir_q  <= DIR_RIGHT;
			fduty_q <= '0;
			bduty_q <= '0;
		end else begin
			if (pop) begin
				mode_q  <= mode_d;
				brake_q <= brake_d;
				fdir_q  <= fdir_d;
				bdir_q  <= bdir_d;
				fduty_q <= fduty_d;
				bduty_q <= bduty_d;
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
